>>> sv/mel_pkg.sv
package mel_pkg;

  // log geometry and timer width
  localparam int LOG_DEPTH = 12;
  localparam int TIME_BITS = 32;
  localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int AGE_SHIFT = 3;
  localparam int AGE_MAX   = 63;

  // status nibbles of the channel messages
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_BEND     = 4'hE;
  localparam logic [3:0] CHAN_MASK     = 4'hF;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_MERGE  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_OUT,
    ST_RD_MISS,
    ST_HEAD_REQ,
    ST_HEAD_CHK,
    ST_SCAN_REQ,
    ST_SCAN_CHK,
    ST_MERGE,
    ST_APPEND
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic [3:0] read_index;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [3:0]  slot;
    logic        entry_valid;
    logic [31:0] stamp;
    logic [3:0]  msg_type;
    logic [3:0]  chan;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [5:0]  age_level;
    logic [3:0]  entry_count;
  } rsp_word_t;

  typedef struct packed {
    logic [3:0] msg_type;
    logic [3:0] chan;
    logic [7:0] data_first;
    logic [7:0] data_second;
  } msg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    msg_t                 msg;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/midi_event_log.sv
// a timer tick or an incomplete byte is taken in idle; a read of a stored entry passes
// ST_RD_REQ and ST_RD_OUT, any other read goes to ST_RD_MISS; a finished message goes to
// ST_APPEND into an empty log, else ST_HEAD_REQ and ST_HEAD_CHK, then ST_MERGE or ST_APPEND
// one word per pass, taken only in idle once the last result is loaded; a note-off search
// reads and compares one log entry at a time in ST_SCAN_REQ and ST_SCAN_CHK through the single registered ram port
// reset: clears timer, entry count, ring head, parser and handshake; the log ram is not cleared
module midi_event_log
  import mel_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  state_t               state, state_next;
  logic [TIME_BITS-1:0] tick;
  logic [CNT_W-1:0]     count;
  logic [ADDR_W-1:0]    head;
  logic [7:0]           pend_status;
  logic [7:0]           pend_first;
  logic [1:0]           held;
  msg_t                 msg;
  logic [3:0]           pos;

  logic                 accept;
  logic                 out_free;
  logic [ADDR_W:0]      phys_sum;
  logic [ADDR_W-1:0]    phys;
  logic [ADDR_W-1:0]    head_dec;
  logic [CNT_W-1:0]     count_inc;
  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  entry_t               ram_wr_data;
  logic                 ram_rd_en;
  logic [ENTRY_W-1:0]   ram_rd_data;
  entry_t               rd;
  logic                 rsp_load;
  rsp_word_t            rsp_next;

  logic [3:0]           ptype;
  logic                 status_ok;
  logic                 complete_now;
  msg_t                 msg_new;
  logic                 read_hit;
  logic                 head_is_on;
  logic                 scan_hit;
  logic                 type_ok;
  logic                 data_ok;
  logic                 merge_ok;
  logic                 need_scan;
  logic                 scan_more;
  logic [TIME_BITS-1:0] age_diff;
  logic [TIME_BITS-1:0] age_shift;
  logic [5:0]           age;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign rd       = entry_t'(ram_rd_data);

  // logical position to ring address
  assign phys_sum  = {1'b0, head} + (ADDR_W + 1)'(pos);
  assign phys      = (phys_sum >= (ADDR_W + 1)'(LOG_DEPTH)) ?
                     ADDR_W'(phys_sum - (ADDR_W + 1)'(LOG_DEPTH)) : ADDR_W'(phys_sum);
  assign head_dec  = (head == '0) ? ADDR_W'(LOG_DEPTH - 1) : head - ADDR_W'(1);
  assign count_inc = (count < CNT_W'(LOG_DEPTH)) ? count + CNT_W'(1) : count;

  // byte parser decode
  assign ptype        = pend_status[7:4];
  assign status_ok    = (req.byte_value[7:4] >= TYPE_NOTE_OFF) &&
                        (req.byte_value[7:4] <= TYPE_BEND);
  assign complete_now = (req.action == ACT_BYTE) &&
                        (((held == 2'd1) && ((ptype == TYPE_PROGRAM) ||
                                             (ptype == TYPE_PRESSURE))) ||
                         (held == 2'd2));
  assign msg_new.msg_type    = ptype;
  assign msg_new.chan        = pend_status[3:0] & CHAN_MASK;
  assign msg_new.data_first  = (held == 2'd1) ? req.byte_value : pend_first;
  assign msg_new.data_second = (held == 2'd1) ? 8'd0 : req.byte_value;
  assign read_hit            = 8'(req.read_index) < 8'(count);

  // shared entry compare on the ram read data
  assign head_is_on = (rd.msg.msg_type == TYPE_NOTE_ON) &&
                      (rd.msg.data_first == msg.data_first);
  assign scan_hit   = head_is_on && (rd.msg.chan == msg.chan);
  assign type_ok    = (msg.msg_type == rd.msg.msg_type) ||
                      ((msg.msg_type == TYPE_NOTE_OFF) && (rd.msg.msg_type == TYPE_NOTE_ON));
  assign data_ok    = (((msg.msg_type == TYPE_NOTE_OFF) || (msg.msg_type == TYPE_CTRL)) &&
                       (rd.msg.data_first == msg.data_first)) ||
                      (msg.msg_type == TYPE_BEND) || (msg.msg_type == TYPE_PRESSURE);
  assign merge_ok   = (rd.msg.chan == msg.chan) && type_ok && data_ok;
  assign need_scan  = (msg.msg_type == TYPE_NOTE_OFF) && !head_is_on;
  assign scan_more  = (8'(pos) + 8'd1) < 8'(count);

  // age of the entry read, saturated
  assign age_diff  = tick - rd.stamp;
  assign age_shift = age_diff >> AGE_SHIFT;
  assign age       = (age_shift > TIME_BITS'(AGE_MAX)) ? 6'(AGE_MAX) : age_shift[5:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_BYTE: begin
              if (complete_now) begin
                state_next = (count == '0) ? ST_APPEND : ST_HEAD_REQ;
              end
            end
            ACT_READ: state_next = read_hit ? ST_RD_REQ : ST_RD_MISS;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_REQ:   state_next = ST_RD_OUT;
      ST_RD_OUT:   if (out_free) state_next = ST_IDLE;
      ST_RD_MISS:  if (out_free) state_next = ST_IDLE;
      ST_HEAD_REQ: state_next = ST_HEAD_CHK;
      ST_HEAD_CHK: begin
        if (need_scan) begin
          state_next = ST_SCAN_REQ;
        end else begin
          state_next = merge_ok ? ST_MERGE : ST_APPEND;
        end
      end
      ST_SCAN_REQ: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          state_next = ST_MERGE;
        end else begin
          state_next = scan_more ? ST_SCAN_REQ : ST_APPEND;
        end
      end
      ST_MERGE:    if (out_free) state_next = ST_IDLE;
      ST_APPEND:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = phys;
    rsp_load    = 1'b0;
    ram_wr_data.stamp = tick;
    ram_wr_data.msg   = msg;
    rsp_next = '0;
    rsp_next.slot        = pos;
    rsp_next.entry_count = 4'(count);
    unique case (state) inside
      ST_IDLE: req_ready = 1'b1;
      ST_RD_REQ, ST_HEAD_REQ, ST_SCAN_REQ: ram_rd_en = 1'b1;
      ST_RD_OUT: begin
        rsp_load             = out_free;
        rsp_next.resp_kind   = KIND_READ;
        rsp_next.entry_valid = 1'b1;
        rsp_next.stamp       = 32'(rd.stamp);
        rsp_next.msg_type    = rd.msg.msg_type;
        rsp_next.chan        = rd.msg.chan;
        rsp_next.data_first  = rd.msg.data_first;
        rsp_next.data_second = rd.msg.data_second;
        rsp_next.age_level   = age;
      end
      ST_RD_MISS: begin
        rsp_load           = out_free;
        rsp_next.resp_kind = KIND_READ;
      end
      ST_MERGE, ST_APPEND: begin
        rsp_load             = out_free;
        ram_wr_en            = out_free;
        rsp_next.entry_valid = 1'b1;
        rsp_next.stamp       = 32'(tick);
        rsp_next.msg_type    = msg.msg_type;
        rsp_next.chan        = msg.chan;
        rsp_next.data_first  = msg.data_first;
        rsp_next.data_second = msg.data_second;
        if (state == ST_APPEND) begin
          ram_wr_addr          = head_dec;
          rsp_next.resp_kind   = KIND_APPEND;
          rsp_next.slot        = 4'd0;
          rsp_next.entry_count = 4'(count_inc);
        end else begin
          rsp_next.resp_kind   = KIND_MERGE;
        end
      end
      default: req_ready = 1'b0;
    endcase
  end

  // control and parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tick        <= '0;
      count       <= '0;
      head        <= '0;
      pend_status <= 8'd0;
      pend_first  <= 8'd0;
      held        <= 2'd0;
      pos         <= 4'd0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (req.action)
          ACT_TICK: tick <= tick + TIME_BITS'(1);
          ACT_READ: pos <= req.read_index;
          ACT_BYTE: begin
            if (held == 2'd0) begin
              if (status_ok) begin
                pend_status <= req.byte_value;
                held        <= 2'd1;
              end
            end else if (complete_now) begin
              pend_status <= 8'd0;
              held        <= 2'd0;
              pos         <= 4'd0;
            end else begin
              pend_first <= req.byte_value;
              held       <= 2'd2;
            end
          end
          default: held <= held;
        endcase
      end
      if ((state == ST_SCAN_CHK) && !scan_hit && scan_more) begin
        pos <= pos + 4'd1;
      end
      if ((state == ST_HEAD_CHK) && need_scan) begin
        pos <= 4'd0;
      end
      if ((state == ST_APPEND) && out_free) begin
        head  <= head_dec;
        count <= count_inc;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // message and result words
  always_ff @(posedge clk) begin
    if (accept && complete_now) begin
      msg <= msg_new;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  mel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (phys),
    .rd_data (ram_rd_data)
  );

`ifndef NO_ASSERTIONS
  // log fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    8'(count) <= 8'(LOG_DEPTH))
    else $error("entry count above log depth");

  // the search only visits stored entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_CHK) |-> (8'(pos) < 8'(count)))
    else $error("search position beyond stored entries");

  // history check needs at least one entry
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD_REQ) |-> (count != '0))
    else $error("history check with empty log");

  // write results carry a fresh entry
  a_write_fresh: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.resp_kind != KIND_READ)) |->
      (rsp.entry_valid && (rsp.age_level == 6'd0)))
    else $error("write result not fresh");
`endif

endmodule

>>> sv/mel_ram.sv
module mel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> tb/sv/midi_event_log_tb.sv
module midi_event_log_tb
  import mel_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // action code the block ignores
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // polyphonic pressure, a message with two data bytes that never merges
  localparam logic [3:0] TYPE_POLY = 4'hA;

  localparam int RANDOM_ITEMS = 1180;
  localparam int DRAIN_CYCLES = 48;
  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int MAX_LOGGED   = 40;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY
  } rx_style_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_word_t rsp;

  // shadow of the log, timer and byte parser
  entry_t               log_mem [LOG_DEPTH];
  int                   log_fill;
  logic [TIME_BITS-1:0] tick_now;
  logic [7:0]           held_status;
  logic [7:0]           held_first;
  int                   bytes_in;

  rsp_word_t   due_replies [$];
  int          mismatch_count;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned rsp_hold_cycles;
  int unsigned idle_cycles;

  midi_event_log dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reply word as the block should build it from the shadow log
  function automatic rsp_word_t log_reply(kind_t kind, int pos, bit present);
    rsp_word_t            w;
    logic [TIME_BITS-1:0] diff;
    w = '0;
    w.resp_kind   = kind;
    w.slot        = 4'(pos);
    w.entry_count = 4'(log_fill);
    if (present && pos < LOG_DEPTH) begin
      diff          = (tick_now - log_mem[pos].stamp) >> AGE_SHIFT;
      w.entry_valid = 1'b1;
      w.stamp       = log_mem[pos].stamp;
      w.msg_type    = log_mem[pos].msg.msg_type;
      w.chan        = log_mem[pos].msg.chan;
      w.data_first  = log_mem[pos].msg.data_first;
      w.data_second = log_mem[pos].msg.data_second;
      w.age_level   = (diff > AGE_MAX) ? 6'(AGE_MAX) : 6'(diff);
    end
    return w;
  endfunction

  // expected words wait here in order
  task automatic queue_reply(rsp_word_t w);
    due_replies = {due_replies, w};
  endtask

  // merge a finished message into the log or push it as the newest entry
  task automatic log_message(logic [3:0] t, logic [3:0] ch, logic [7:0] d1, logic [7:0] d2);
    int cand;
    bit hit;
    bit type_ok;
    bit data_ok;
    cand = 0;
    hit  = 1'b0;
    if (log_fill > 0) begin
      hit = 1'b1;
      // note-off not matching the newest note-on looks further back
      if (t == TYPE_NOTE_OFF && !(log_mem[0].msg.msg_type == TYPE_NOTE_ON &&
                                  log_mem[0].msg.data_first == d1)) begin
        hit = 1'b0;
        for (int i = 0; i < log_fill; i++) begin
          if (!hit && log_mem[i].msg.msg_type == TYPE_NOTE_ON &&
              log_mem[i].msg.data_first == d1 && log_mem[i].msg.chan == ch) begin
            cand = i;
            hit  = 1'b1;
          end
        end
      end
    end
    if (hit) begin
      type_ok = (t == log_mem[cand].msg.msg_type) ||
                (t == TYPE_NOTE_OFF && log_mem[cand].msg.msg_type == TYPE_NOTE_ON);
      data_ok = ((t == TYPE_NOTE_OFF || t == TYPE_CTRL) && log_mem[cand].msg.data_first == d1) ||
                t == TYPE_BEND || t == TYPE_PRESSURE;
      if (log_mem[cand].msg.chan == ch && type_ok && data_ok) begin
        log_mem[cand].stamp = tick_now;
        log_mem[cand].msg   = {t, ch, d1, d2};
        queue_reply(log_reply(KIND_MERGE, cand, 1'b1));
        return;
      end
    end
    for (int i = LOG_DEPTH - 1; i > 0; i--) log_mem[i] = log_mem[i-1];
    log_mem[0].stamp = tick_now;
    log_mem[0].msg   = {t, ch, d1, d2};
    if (log_fill < LOG_DEPTH) log_fill++;
    queue_reply(log_reply(KIND_APPEND, 0, 1'b1));
  endtask

  // byte parser: status, then one or two data bytes
  task automatic take_byte(logic [7:0] b);
    logic [3:0] t;
    logic [3:0] ch;
    t  = held_status[7:4];
    ch = held_status[3:0] & CHAN_MASK;
    if (bytes_in == 0) begin
      if (b[7:4] >= TYPE_NOTE_OFF && b[7:4] <= TYPE_BEND) begin
        held_status = b;
        bytes_in    = 1;
      end
    end else if (bytes_in == 1 && (t == TYPE_PROGRAM || t == TYPE_PRESSURE)) begin
      bytes_in    = 0;
      held_status = '0;
      log_message(t, ch, b, 8'h00);
    end else if (bytes_in == 1) begin
      held_first = b;
      bytes_in   = 2;
    end else begin
      bytes_in    = 0;
      held_status = '0;
      log_message(t, ch, held_first, b);
    end
  endtask

  task automatic track_event_log(req_word_t w);
    case (w.action)
      ACT_TICK: tick_now = tick_now + 1'b1;
      ACT_READ: queue_reply(log_reply(KIND_READ, w.read_index,
                                      w.read_index < log_fill));
      ACT_BYTE: take_byte(w.byte_value);
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_LOGGED)
      $display("mismatch %s: got %0h want %0h at %0t ns", what, got, want, $time);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // send one word, with gaps between bursts
  task automatic send_word(req_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(12, 1);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(32, 1);
    end
    burst_left--;
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    track_event_log(w);
    words_sent++;
  endtask

  // fields the action does not use carry random values
  function automatic req_word_t noisy_word(logic [1:0] act);
    req_word_t w;
    w.action     = act;
    w.byte_value = 8'($urandom_range(255));
    w.read_index = 4'($urandom_range(15));
    return w;
  endfunction

  task automatic send_byte(logic [7:0] b);
    req_word_t w;
    w = noisy_word(ACT_BYTE);
    w.byte_value = b;
    send_word(w);
  endtask

  task automatic send_tick();
    send_word(noisy_word(ACT_TICK));
  endtask

  task automatic send_read(logic [3:0] idx);
    req_word_t w;
    w = noisy_word(ACT_READ);
    w.read_index = idx;
    send_word(w);
  endtask

  task automatic send_message(logic [3:0] t, logic [3:0] ch, logic [7:0] d1, logic [7:0] d2);
    send_byte({t, ch});
    send_byte(d1);
    if (t != TYPE_PROGRAM && t != TYPE_PRESSURE) send_byte(d2);
  endtask

  function automatic logic [3:0] pick_type();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return TYPE_NOTE_ON;
    if (r < 55) return TYPE_NOTE_OFF;
    if (r < 68) return TYPE_CTRL;
    if (r < 78) return TYPE_BEND;
    if (r < 86) return TYPE_PRESSURE;
    if (r < 94) return TYPE_PROGRAM;
    return TYPE_POLY;
  endfunction

  // few channels and keys so that merges are common
  function automatic logic [3:0] pick_chan();
    case ($urandom_range(3))
      0: return 4'h0;
      1: return 4'h5;
      2: return 4'hF;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(4))
      0: return 8'h3C;
      1: return 8'h00;
      2: return 8'h7F;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_message();
    logic [3:0] t;
    logic [3:0] ch;
    t  = pick_type();
    ch = pick_chan();
    send_message(t, ch, pick_key(), 8'($urandom_range(255)));
  endtask

  // stop offering and let every due reply come back
  task automatic wait_drain();
    req_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // empty log, ignored inputs, and merges of a note-off, a controller and channel pressure
  task automatic test_directed();
    req_word_t w;
    send_read(4'hF);
    w = noisy_word(ACT_SPARE);
    send_word(w);
    send_byte(8'hF8);
    send_byte(8'h45);
    send_message(TYPE_NOTE_ON, 4'h0, 8'h3C, 8'h7F);
    send_tick();
    send_message(TYPE_NOTE_OFF, 4'h0, 8'h3C, 8'h00);
    send_message(TYPE_CTRL, 4'hF, 8'h07, 8'h40);
    send_message(TYPE_CTRL, 4'hF, 8'h07, 8'hFF);
    send_message(TYPE_BEND, 4'h5, 8'h00, 8'h40);
    send_message(TYPE_PRESSURE, 4'h2, 8'h80, 8'h00);
    send_message(TYPE_PRESSURE, 4'h2, 8'h55, 8'h00);
    send_message(TYPE_PROGRAM, 4'h3, 8'h12, 8'h00);
    send_message(TYPE_NOTE_OFF, 4'h1, 8'h10, 8'h00);
    send_read(4'h6);
    wait_drain();
  endtask

  // more appends than the log holds, then every read position
  task automatic test_log_overflow();
    for (int i = 0; i < LOG_DEPTH + 2; i++)
      send_message(TYPE_PROGRAM, 4'(i), 8'(i * 17), 8'h00);
    for (int i = 0; i < 16; i++) send_read(4'(i));
    wait_drain();
  endtask

  // note-off finding its note-on at the oldest position, and near misses
  task automatic test_note_off_search();
    for (int i = 0; i < LOG_DEPTH; i++)
      send_message(TYPE_NOTE_ON, 4'h3, 8'(8'h10 + i), 8'h64);
    send_message(TYPE_NOTE_OFF, 4'h3, 8'h10, 8'h20);
    send_message(TYPE_NOTE_OFF, 4'h3, 8'(8'h10 + LOG_DEPTH - 1), 8'h00);
    send_message(TYPE_NOTE_OFF, 4'h4, 8'h15, 8'h00);
    // newest note-on matches the key but not the channel
    send_message(TYPE_NOTE_ON, 4'h6, 8'h22, 8'h40);
    send_message(TYPE_NOTE_OFF, 4'h7, 8'h22, 8'h40);
    send_read(4'hB);
    wait_drain();
  endtask

  // ages climbing to saturation
  task automatic test_age_saturation();
    send_message(TYPE_NOTE_ON, 4'h9, 8'h40, 8'h01);
    repeat (7) send_tick();
    send_read(4'h0);
    send_tick();
    send_read(4'h0);
    repeat (495) send_tick();
    send_read(4'h0);
    send_tick();
    send_read(4'h0);
    repeat (20) send_tick();
    send_read(4'h0);
    send_read(4'h1);
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rsp_hold_cycles = LONG_HOLD;
    repeat (30) begin
      send_read(4'($urandom_range(15)));
      send_random_message();
    end
    wait_drain();
  endtask

  // mostly well-formed messages, with ticks, reads, noise and cut messages
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    req_word_t   w;
    start = words_sent;
    while (words_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_random_message();
      end else if (pick < 72) begin
        repeat (($urandom_range(19) == 0) ? $urandom_range(100, 60) : $urandom_range(4, 1))
          send_tick();
      end else if (pick < 88) begin
        if ($urandom_range(3) == 0 || log_fill == 0) send_read(4'($urandom_range(15)));
        else send_read(4'($urandom_range(log_fill - 1)));
      end else if (pick < 94) begin
        send_byte(8'($urandom_range(255)));
      end else if (pick < 98) begin
        send_byte({pick_type(), pick_chan()});
        send_byte(pick_key());
      end else begin
        w = noisy_word(ACT_SPARE);
        send_word(w);
      end
    end
    wait_drain();
  endtask

  initial begin
    rst             = 1'b1;
    req_valid       = 1'b0;
    req             = '0;
    rsp_ready       = 1'b0;
    log_fill        = 0;
    tick_now        = '0;
    held_status     = '0;
    held_first      = '0;
    bytes_in        = 0;
    mismatch_count  = 0;
    words_sent      = 0;
    burst_left      = 0;
    rsp_hold_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_log_overflow();
    test_note_off_search();
    test_age_saturation();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: ready styles that change at random, plus long holds
  initial begin : rsp_side
    rx_style_t   style;
    int unsigned style_left;
    int unsigned beat;
    style      = RX_OPEN;
    style_left = 0;
    beat       = 0;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ready <= 1'b0;
        repeat (rsp_hold_cycles - 1) @(posedge clk);
        rsp_hold_cycles = 0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(3));
          style_left = $urandom_range(300, 40);
        end
        style_left--;
        beat++;
        case (style)
          RX_OPEN:   rsp_ready <= 1'b1;
          RX_COIN:   rsp_ready <= ($urandom_range(1) == 0);
          RX_EVERY4: rsp_ready <= (beat % 4 == 0);
          default:   rsp_ready <= ($urandom_range(99) < 85);
        endcase
      end
    end
  end

  // compare each returned word with the oldest one due
  always @(posedge clk) begin : check_words
    rsp_word_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_replies.size() == 0) begin
        report_mismatch("word with nothing due, kind", 32'(rsp.resp_kind), 32'h0);
      end else begin
        want = due_replies.pop_front();
        check_field("resp_kind", 32'(rsp.resp_kind), 32'(want.resp_kind));
        check_field("slot", 32'(rsp.slot), 32'(want.slot));
        check_field("entry_valid", 32'(rsp.entry_valid), 32'(want.entry_valid));
        check_field("stamp", rsp.stamp, want.stamp);
        check_field("msg_type", 32'(rsp.msg_type), 32'(want.msg_type));
        check_field("chan", 32'(rsp.chan), 32'(want.chan));
        check_field("data_first", 32'(rsp.data_first), 32'(want.data_first));
        check_field("data_second", 32'(rsp.data_second), 32'(want.data_second));
        check_field("age_level", 32'(rsp.age_level), 32'(want.age_level));
        check_field("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
